// ===== src/sctt_pkg.sv =====
// Package for the sorted commit time table: transaction types, request codes, cell control.
package sctt_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int KEY_FIELD_WIDTH = 64;
    localparam int COUNT_FIELD_WIDTH = 5;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_COMMIT   = 2'd1;
    localparam logic [1:0] REQ_ROLLBACK = 2'd2;

    localparam logic [COUNT_FIELD_WIDTH-1:0] WARN_RESET = 5'd3;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [KEY_FIELD_WIDTH-1:0] time_key;
        logic [VALUE_WIDTH-1:0]     pair_value;
        logic                       allow_unordered;
    } req_t;

    typedef struct packed {
        logic                         tick_valid;
        logic [VALUE_WIDTH-1:0]       tick_value;
        logic [COUNT_FIELD_WIDTH-1:0] entry_count;
        logic                         order_error;
        logic                         table_full;
        logic                         many_entries;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_COMPARE,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctrl_t;

endpackage

// ===== src/sctt_cell.sv =====
// One table slot: holds a key and value, compares against the request key, shifts with neighbors.
module sctt_cell
    import sctt_pkg::*;
#(
    parameter int TIME_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctrl_t             ctrl,
    input  logic [TIME_WIDTH-1:0]  time_key,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [TIME_WIDTH-1:0]  left_key,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic                   left_le,
    input  logic [TIME_WIDTH-1:0]  right_key,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  logic                   right_le,
    output logic [TIME_WIDTH-1:0]  key,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   le,
    output logic                   eq
);

    logic [TIME_WIDTH-1:0]  key_reg;
    logic [TIME_WIDTH-1:0]  key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   le_reg;
    logic                   le_next;
    logic                   eq_reg;
    logic                   eq_next;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        le_next    = le_reg;
        eq_next    = eq_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_COMPARE:
            begin
                le_next = ctrl.occupied && (key_reg <= time_key);
                eq_next = ctrl.occupied && (key_reg == time_key);
            end
            CELL_INSERT:
            begin
                // first slot past the at-or-below run takes the new pair, later slots move up
                if (left_le && !le_reg)
                begin
                    key_next   = time_key;
                    value_next = new_value;
                end
                else if (!left_le)
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
            end
            CELL_SHIFT:
            begin
                key_next   = right_key;
                value_next = right_value;
                le_next    = right_le;
                eq_next    = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            le_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            le_reg <= le_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign le    = le_reg;
    assign eq    = eq_reg;

endmodule

// ===== src/sorted_commit_time_table.sv =====
// Top level of the sorted commit time table: control sequencer and the row of slot cells.
//
// The table holds up to DEPTH (commit time, value) pairs in ascending key order in a row
// of cells; slot i is in use when i is below the entry count. Each request transaction
// produces exactly one result transaction. The block works on one request at a time:
// an accepted request first passes a compare step in which every cell compares its key
// with the request key, then its own steps, then a finish step that loads the result
// register. In an insert's decide step the insert and any shift up happen across all
// cells at once. A commit point update removes every entry at or below the commit
// point: the row shifts down one slot per cycle and the value leaving slot 0 last is
// reported. A rollback drops entries above the rollback time from the top, one per
// cycle. An unknown request type goes from the compare step straight to the finish
// step. A result waiting in the output register does not block acceptance of the next
// request; only the final load waits for the output register to free up. The warning
// threshold register resets to 3 and is written through cfg_write_en and cfg_write_data;
// the user must do so only while the block is idle, as the block does not enforce it.
// Reset runs no clearing pass: slot contents are meaningful only below the entry count.
module sorted_commit_time_table
    import sctt_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  req_t                         in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output rsp_t                         out_data,
    input  logic                         cfg_write_en,
    input  logic [COUNT_FIELD_WIDTH-1:0] cfg_write_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > COUNT_FIELD_WIDTH) ? CW : COUNT_FIELD_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_SHIFT,
        ST_TRIM,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    req_t                         req_reg;
    req_t                         req_next;
    rsp_t                         res_reg;
    rsp_t                         res_next;
    rsp_t                         out_data_reg;
    rsp_t                         out_data_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [COUNT_FIELD_WIDTH-1:0] warn_reg;
    logic [COUNT_FIELD_WIDTH-1:0] warn_next;

    cell_op_t                     cell_op;
    logic [TIME_WIDTH-1:0]        req_key;
    logic [TIME_WIDTH-1:0]        key_vec [DEPTH];
    logic [VALUE_WIDTH-1:0]       val_vec [DEPTH];
    logic [DEPTH-1:0]             le_vec;
    logic [DEPTH-1:0]             eq_vec;
    logic [DEPTH-1:0]             top_vec;
    logic [DEPTH-1:0]             occ_vec;

    logic                         out_free;
    logic                         order_bad;
    logic                         dup_key;
    logic                         trim_hit;
    logic [CW-1:0]                count_inc;
    logic [CMPW-1:0]              count_ext;
    logic [CMPW-1:0]              count_inc_ext;
    logic [CMPW-1:0]              warn_ext;

    // only the low TIME_WIDTH bits of the request key take part
    assign req_key = req_reg.time_key[TIME_WIDTH-1:0];

    // slot row: each cell talks only to its two neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t             ctrl;
        logic [TIME_WIDTH-1:0]  l_key;
        logic [VALUE_WIDTH-1:0] l_value;
        logic                   l_le;
        logic [TIME_WIDTH-1:0]  r_key;
        logic [VALUE_WIDTH-1:0] r_value;
        logic                   r_le;

        assign occ_vec[i] = (count_reg > CW'(i));
        assign top_vec[i] = (count_reg == CW'(i + 1));
        assign ctrl.op       = cell_op;
        assign ctrl.occupied = occ_vec[i];

        if (i == 0)
        begin : g_first
            assign l_key   = '0;
            assign l_value = '0;
            assign l_le    = 1'b1;
        end
        else
        begin : g_inner_l
            assign l_key   = key_vec[i-1];
            assign l_value = val_vec[i-1];
            assign l_le    = le_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_key   = '0;
            assign r_value = '0;
            assign r_le    = 1'b0;
        end
        else
        begin : g_inner_r
            assign r_key   = key_vec[i+1];
            assign r_value = val_vec[i+1];
            assign r_le    = le_vec[i+1];
        end

        sctt_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .time_key    (req_key),
            .new_value   (req_reg.pair_value),
            .left_key    (l_key),
            .left_value  (l_value),
            .left_le     (l_le),
            .right_key   (r_key),
            .right_value (r_value),
            .right_le    (r_le),
            .key         (key_vec[i]),
            .value       (val_vec[i]),
            .le          (le_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    // newest key at or above the request key breaks strict order
    assign order_bad = |(top_vec & ~(le_vec & ~eq_vec));
    // keys are unique and sorted, so any equal slot is the last at-or-below slot
    assign dup_key   = |eq_vec;
    // the top entry lies above the rollback time
    assign trim_hit  = |(top_vec & ~le_vec);

    assign count_inc     = count_reg + CW'(1);
    assign count_ext     = CMPW'(count_reg);
    assign count_inc_ext = CMPW'(count_inc);
    assign warn_ext      = CMPW'(warn_reg);

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        warn_next      = warn_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        cell_op        = CELL_HOLD;

        if (cfg_write_en)
        begin
            warn_next = cfg_write_data;
        end

        // drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    res_next   = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cell_op = CELL_COMPARE;
                unique case (req_reg.req_type)
                    REQ_INSERT:   state_next = ST_DECIDE;
                    REQ_COMMIT:   state_next = ST_SHIFT;
                    REQ_ROLLBACK: state_next = ST_TRIM;
                    default:      state_next = ST_FINISH;
                endcase
            end
            ST_DECIDE:
            begin
                if (!req_reg.allow_unordered && (count_reg != '0) && order_bad)
                begin
                    res_next.order_error = 1'b1;
                end
                else if (dup_key)
                begin
                    res_next.many_entries = (count_ext >= warn_ext);
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    res_next.table_full = 1'b1;
                end
                else
                begin
                    cell_op               = CELL_INSERT;
                    count_next            = count_inc;
                    res_next.many_entries = (count_inc_ext >= warn_ext);
                end
                state_next = ST_FINISH;
            end
            ST_SHIFT:
            begin
                // advance the row down while slot 0 is at or below the commit point
                if (le_vec[0])
                begin
                    cell_op             = CELL_SHIFT;
                    count_next          = count_reg - CW'(1);
                    res_next.tick_valid = 1'b1;
                    res_next.tick_value = val_vec[0];
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_TRIM:
            begin
                if (trim_hit)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_data_next             = res_reg;
                    out_data_next.entry_count = count_ext[COUNT_FIELD_WIDTH-1:0];
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            warn_reg      <= WARN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            warn_reg      <= warn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> ((le_vec & (le_vec + DEPTH'(1))) == '0))
        else $error("at-or-below slots do not form a prefix; table order lost");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && le_vec[0]) |-> (count_reg != '0))
        else $error("commit shift on an empty table");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish step");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the sorted commit time table: directed and random requests against a predictor.
module tb_top;
    import sctt_pkg::*;

    localparam int          DEPTH       = 16;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
    localparam logic [63:0] KEY_MAX     = '1;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    req_t                         in_data;
    logic                         out_valid;
    logic                         out_stall;
    rsp_t                         out_data;
    logic                         cfg_write_en;
    logic [COUNT_FIELD_WIDTH-1:0] cfg_write_data;

    sorted_commit_time_table #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (64)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // Shadow copy of the table, kept in ascending key order like the block's row of slots.
    logic [63:0] slot_key   [DEPTH];
    logic [63:0] slot_value [DEPTH];
    int          slot_count;
    int          warn_level;

    // Results predicted at request acceptance, oldest first.
    rsp_t        pending_results[$];

    // Base key used when the table is empty; tracks the latest commit point.
    logic [63:0] key_floor;

    // Flow-control mix: percent of cycles the sender idles and the receiver stalls.
    int          sender_gap_pct;
    int          receiver_stall_pct;

    int          mismatch_count;
    int          request_count;
    int          tick_count;
    int          order_drop_count;
    int          full_drop_count;
    int          warning_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver side: stall at random per the current mix, changing only at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Apply one request to the shadow table and return the result the block should give.
    function automatic rsp_t apply_request(req_t req);
        rsp_t        res;
        int          below;
        int          i;
        logic [63:0] t;
        res = '0;
        t = req.time_key;
        below = 0;
        while (below < slot_count && slot_key[below] <= t)
            below++;
        case (req.req_type)
            REQ_INSERT:
            begin
                if (!req.allow_unordered && slot_count > 0 && !(slot_key[slot_count-1] < t))
                begin
                    res.order_error = 1'b1;
                end
                else if (below > 0 && slot_key[below-1] == t)
                begin
                    // Key already held: table untouched, warning still evaluated.
                    res.many_entries = (slot_count >= warn_level);
                end
                else if (slot_count >= DEPTH)
                begin
                    res.table_full = 1'b1;
                end
                else
                begin
                    for (i = slot_count; i > below; i--)
                    begin
                        slot_key[i]   = slot_key[i-1];
                        slot_value[i] = slot_value[i-1];
                    end
                    slot_key[below]   = t;
                    slot_value[below] = req.pair_value;
                    slot_count++;
                    res.many_entries = (slot_count >= warn_level);
                end
            end
            REQ_COMMIT:
            begin
                // Drop every entry at or below the commit point; report the last one dropped.
                if (below > 0)
                begin
                    res.tick_valid = 1'b1;
                    res.tick_value = slot_value[below-1];
                    for (i = 0; i + below < slot_count; i++)
                    begin
                        slot_key[i]   = slot_key[i+below];
                        slot_value[i] = slot_value[i+below];
                    end
                    slot_count -= below;
                end
            end
            REQ_ROLLBACK:
            begin
                slot_count = below;
            end
            default:
            begin
                // Unknown request type: nothing changes, only the count is reported.
            end
        endcase
        res.entry_count = COUNT_FIELD_WIDTH'(slot_count);
        tick_count       += int'(res.tick_valid);
        order_drop_count += int'(res.order_error);
        full_drop_count  += int'(res.table_full);
        warning_count    += int'(res.many_entries);
        return res;
    endfunction

    // Result checker: compare every accepted result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: %p", out_data);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.tick_valid !== want.tick_valid)
                begin
                    $error("tick_valid: expected %0h, got %0h", want.tick_valid,
                           out_data.tick_valid);
                    mismatch_count++;
                end
                if (out_data.tick_value !== want.tick_value)
                begin
                    $error("tick_value: expected %0h, got %0h", want.tick_value,
                           out_data.tick_value);
                    mismatch_count++;
                end
                if (out_data.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           out_data.entry_count);
                    mismatch_count++;
                end
                if (out_data.order_error !== want.order_error)
                begin
                    $error("order_error: expected %0h, got %0h", want.order_error,
                           out_data.order_error);
                    mismatch_count++;
                end
                if (out_data.table_full !== want.table_full)
                begin
                    $error("table_full: expected %0h, got %0h", want.table_full,
                           out_data.table_full);
                    mismatch_count++;
                end
                if (out_data.many_entries !== want.many_entries)
                begin
                    $error("many_entries: expected %0h, got %0h", want.many_entries,
                           out_data.many_entries);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one request transaction. Called at a falling edge; returns at a falling edge
    // with valid still high so back-to-back requests need no drop in between.
    task automatic send_request(req_t req);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.push_back(apply_request(req));
        request_count++;
        @(negedge clk);
    endtask

    task automatic send_fields(logic [1:0] kind, logic [63:0] key, logic [63:0] value,
                               logic unordered);
        req_t req;
        req.req_type        = kind;
        req.time_key        = key;
        req.pair_value      = value;
        req.allow_unordered = unordered;
        send_request(req);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_all_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the warning threshold while the block is idle.
    task automatic set_threshold(int level);
        wait_all_results();
        cfg_write_en   = 1'b1;
        cfg_write_data = COUNT_FIELD_WIDTH'(level);
        @(negedge clk);
        cfg_write_en = 1'b0;
        warn_level   = level;
    endtask

    // Build one random request. Most are well-formed: ordered inserts just above the newest
    // key, commits that retire a few of the oldest entries, rollbacks that trim the newest.
    // The rest are unordered inserts, unknown types and fully random noise.
    task automatic make_request(output req_t req);
        int          pick;
        logic [63:0] top;
        pick = $urandom_range(0, 99);
        top  = (slot_count > 0) ? slot_key[slot_count-1] : key_floor;
        req.req_type        = REQ_INSERT;
        req.time_key        = top + $urandom_range(1, 4);
        req.pair_value      = {$urandom, $urandom};
        req.allow_unordered = 1'b0;
        if (pick < 50)
        begin
            // ordered insert as set above
        end
        else if (pick < 62)
        begin
            req.allow_unordered = 1'b1;
            req.time_key = key_floor + $urandom_range(0, 2 * slot_count + 4);
        end
        else if (pick < 78)
        begin
            req.req_type = REQ_COMMIT;
            if (slot_count > 0 && $urandom_range(0, 9) != 0)
                req.time_key = slot_key[$urandom_range(0, (slot_count - 1) / 3)];
            else if ($urandom_range(0, 3) == 0)
                req.time_key = KEY_MAX;
            else
                req.time_key = key_floor - $urandom_range(0, 2);
            if (req.time_key > key_floor && req.time_key != KEY_MAX)
                key_floor = req.time_key;
        end
        else if (pick < 90)
        begin
            req.req_type = REQ_ROLLBACK;
            if (slot_count > 0)
                req.time_key = slot_key[$urandom_range((slot_count * 2) / 3, slot_count - 1)]
                               - $urandom_range(0, 1);
            else
                req.time_key = {$urandom, $urandom};
        end
        else if (pick < 95)
        begin
            req.req_type        = REQ_UNKNOWN;
            req.time_key        = {$urandom, $urandom};
            req.allow_unordered = 1'($urandom_range(0, 1));
        end
        else
        begin
            req.req_type        = 2'($urandom_range(0, 2));
            req.time_key        = {$urandom, $urandom};
            req.allow_unordered = 1'($urandom_range(0, 1));
        end
    endtask

    task automatic run_traffic(int items, int gap_pct, int stall_pct);
        req_t req;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        // Move the key region now and then so the upper key bits see real sequences.
        if ($urandom_range(0, 1) != 0)
            key_floor = {$urandom, $urandom} >> $urandom_range(1, 60);
        repeat (items)
        begin
            make_request(req);
            send_request(req);
        end
        wait_all_results();
    endtask

    // Strict order, duplicates, mid-table insert, commit and rollback on a small table.
    task automatic test_insert_order();
        send_fields(REQ_INSERT, 64'd0, KEY_MAX, 1'b0);
        send_fields(REQ_INSERT, 64'd0, 64'h1234, 1'b0);        // not above newest: drop
        send_fields(REQ_INSERT, 64'd0, 64'h5678, 1'b1);        // duplicate key
        send_fields(REQ_INSERT, KEY_MAX, 64'd0, 1'b0);
        send_fields(REQ_INSERT, 64'd3, {$urandom, $urandom}, 1'b1);
        send_fields(REQ_COMMIT, 64'd3, 64'd0, 1'b0);           // retires keys 0 and 3
        send_fields(REQ_COMMIT, 64'd2, KEY_MAX, 1'b1);         // nothing at or below
        send_fields(REQ_ROLLBACK, 64'd0, 64'd0, 1'b0);         // empties the table
        send_fields(REQ_UNKNOWN, KEY_MAX, KEY_MAX, 1'b1);
        wait_all_results();
    endtask

    // Fill every slot, then hit the full-table drop, a duplicate at full, and a full commit.
    task automatic test_full_table();
        int k;
        for (k = 1; k <= DEPTH; k++)
            send_fields(REQ_INSERT, 64'(k), {$urandom, $urandom}, 1'b0);
        send_fields(REQ_INSERT, 64'(DEPTH + 1), 64'd1, 1'b0);
        send_fields(REQ_INSERT, 64'd0, 64'd2, 1'b1);           // new key, passes order check
        send_fields(REQ_INSERT, 64'd5, 64'd3, 1'b1);           // duplicate while full
        send_fields(REQ_COMMIT, KEY_MAX, 64'd0, 1'b0);
        wait_all_results();
    endtask

    // Warning threshold at zero, at the table depth, and beyond it.
    task automatic test_threshold_extremes();
        set_threshold(0);
        run_traffic(120, 19, 19);
        set_threshold(DEPTH);
        run_traffic(120, 19, 19);
        set_threshold((1 << COUNT_FIELD_WIDTH) - 1);
        run_traffic(80, 19, 19);
    endtask

    // Random traffic under each sender and receiver idling mix.
    task automatic test_flow_control();
        set_threshold($urandom_range(1, DEPTH - 1));
        run_traffic(330, 0, 0);
        set_threshold($urandom_range(1, DEPTH - 1));
        run_traffic(330, 50, 0);
        set_threshold($urandom_range(1, DEPTH - 1));
        run_traffic(330, 0, 50);
        set_threshold($urandom_range(1, DEPTH - 1));
        run_traffic(330, 19, 19);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        in_data            = '0;
        out_stall          = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        slot_count         = 0;
        warn_level         = int'(WARN_RESET);
        key_floor          = '0;
        mismatch_count     = 0;
        request_count      = 0;
        tick_count         = 0;
        order_drop_count   = 0;
        full_drop_count    = 0;
        warning_count      = 0;
        foreach (slot_key[i])
        begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_insert_order();
        test_full_table();
        test_threshold_extremes();
        test_flow_control();

        receiver_stall_pct = 0;
        wait_all_results();
        repeat (20) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("tb: %0d requests, %0d commit ticks, %0d order drops, %0d full drops,",
                 request_count, tick_count, order_drop_count, full_drop_count);
        $display("tb: %0d warnings; thresholds 0, 3, 16, 31 and random; four idling mixes",
                 warning_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
